// ===== src/ert_pkg.sv =====
// Shared types, codes and helper functions for the electrode scan sequencer.
package ert_pkg;

  localparam int unsigned MAX_ELECTRODES = 16;
  localparam logic [4:0] MIN_COUNT = 5'd8;
  localparam logic [4:0] MAX_COUNT = 5'(MAX_ELECTRODES);

  // drive modes
  localparam logic [2:0] MODE_STANDBY   = 3'd0;
  localparam logic [2:0] MODE_CALIBRATE = 3'd1;
  localparam logic [2:0] MODE_ADJACENT  = 3'd2;
  localparam logic [2:0] MODE_PP        = 3'd3;
  localparam logic [2:0] MODE_PP_BOTH   = 3'd4;

  // scan directions
  localparam logic [1:0] DIR_DOWN = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;

  // commands
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_DRIVE_MODE      = 2'd0;
  localparam logic [1:0] REG_SCAN_DIRECTION  = 2'd1;
  localparam logic [1:0] REG_ELECTRODE_COUNT = 2'd2;
  localparam logic [1:0] REG_GROUND_OFFSET   = 2'd3;

  // reset values
  localparam logic [2:0]  RST_DRIVE_MODE      = MODE_ADJACENT;
  localparam logic [1:0]  RST_SCAN_DIRECTION  = DIR_UP;
  localparam logic [4:0]  RST_ELECTRODE_COUNT = 5'd16;
  localparam logic [15:0] RST_GROUND_OFFSET   = 16'd31360;

  // initial electrodes for pseudo polar modes
  localparam logic [3:0] PP_SINK     = 4'd7;
  localparam logic [3:0] PP_SENSE_NEG = 4'd1;

  typedef struct packed {
    logic [2:0]  drive_mode;
    logic [1:0]  scan_direction;
    logic [4:0]  count;          // saturated electrode count
    logic [15:0] ground_offset;
  } cfg_t;

  typedef struct packed {
    logic               sample_valid;
    logic signed [15:0] voltage;
    logic [3:0]         sense_pos_used;
    logic [3:0]         source_used;
    logic [3:0]         sink_used;
    logic [7:0]         current_mux_byte;
    logic [7:0]         voltage_mux_byte;
    logic               frame_last;
    logic               mux_disable;
  } res_t;

  function automatic logic [4:0] sat_count(input logic [4:0] c);
    logic [4:0] r;
    r = c;
    if (c < MIN_COUNT) r = MIN_COUNT;
    if (c > MAX_COUNT) r = MAX_COUNT;
    return r;
  endfunction

  function automatic logic [3:0] step_elec(input logic [3:0] v, input logic [4:0] count,
                                           input logic [1:0] dir);
    logic [4:0] inc;
    logic [4:0] top;
    logic [3:0] r;
    inc = {1'b0, v} + 5'd1;
    top = count - 5'd1;
    case (dir)
      DIR_UP:   r = (inc < count) ? inc[3:0] : 4'd0;
      DIR_DOWN: r = (v != 4'd0) ? v - 4'd1 : top[3:0];
      default:  r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== src/ert_cfg_regs.sv =====
// Configuration registers of the electrode scan sequencer.
module ert_cfg_regs import ert_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  logic [2:0]  drive_mode;
  logic [1:0]  scan_direction;
  logic [4:0]  electrode_count;
  logic [15:0] ground_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode      <= RST_DRIVE_MODE;
      scan_direction  <= RST_SCAN_DIRECTION;
      electrode_count <= RST_ELECTRODE_COUNT;
      ground_offset   <= RST_GROUND_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DRIVE_MODE:      drive_mode      <= cfg_data[2:0];
        REG_SCAN_DIRECTION:  scan_direction  <= cfg_data[1:0];
        REG_ELECTRODE_COUNT: electrode_count <= cfg_data[4:0];
        REG_GROUND_OFFSET:   ground_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.drive_mode     = drive_mode;
    cfg.scan_direction = scan_direction;
    cfg.count          = sat_count(electrode_count);
    cfg.ground_offset  = ground_offset;
  end

endmodule

// ===== src/ert_scan_core.sv =====
// Electrode position state and per-word result logic.
module ert_scan_core import ert_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic        cmd,
  input  logic [15:0] adc_raw,
  output res_t        res
);

  logic [3:0] source_pos, sink_pos, sense_pos, sense_neg, step_in_frame;
  logic [3:0] source_pos_next, sink_pos_next, sense_pos_next, sense_neg_next;
  logic [3:0] step_in_frame_next;
  logic       standby;
  logic       frame_end;
  logic [4:0] step_inc;

  assign standby  = (cfg.drive_mode == MODE_STANDBY) || (cfg.drive_mode > MODE_PP_BOTH);
  assign step_inc = {1'b0, step_in_frame} + 5'd1;
  assign frame_end = (step_inc >= cfg.count);

  always_comb begin
    source_pos_next    = source_pos;
    sink_pos_next      = sink_pos;
    sense_pos_next     = sense_pos;
    sense_neg_next     = sense_neg;
    step_in_frame_next = step_in_frame;

    res.sample_valid   = 1'b0;
    res.voltage        = '0;
    res.sense_pos_used = '0;
    res.source_used    = '0;
    res.sink_used      = '0;
    res.frame_last     = 1'b0;
    res.mux_disable    = standby;

    if (cmd == CMD_START) begin
      step_in_frame_next = '0;
      case (cfg.drive_mode)
        MODE_CALIBRATE, MODE_ADJACENT: begin
          source_pos_next = 4'd1;
          sink_pos_next   = 4'd0;
          sense_pos_next  = 4'd1;
          sense_neg_next  = 4'd0;
        end
        MODE_PP: begin
          source_pos_next = 4'd0;
          sink_pos_next   = PP_SINK;
          sense_pos_next  = 4'd0;
          sense_neg_next  = PP_SENSE_NEG;
        end
        MODE_PP_BOTH: begin
          source_pos_next = 4'd0;
          sink_pos_next   = PP_SINK;
          sense_pos_next  = 4'd0;
          sense_neg_next  = PP_SINK;
        end
        default: ;
      endcase
    end else if (!standby) begin
      res.sample_valid   = 1'b1;
      res.voltage        = signed'(adc_raw - cfg.ground_offset);
      res.sense_pos_used = sense_pos;
      res.source_used    = source_pos;
      res.sink_used      = sink_pos;
      res.frame_last     = frame_end;

      sense_pos_next = step_elec(sense_pos, cfg.count, cfg.scan_direction);
      sense_neg_next = step_elec(sense_neg, cfg.count, cfg.scan_direction);
      // calibrate steps drive pair every word, adjacent only at frame end
      if ((cfg.drive_mode == MODE_CALIBRATE) ||
          ((cfg.drive_mode == MODE_ADJACENT) && frame_end)) begin
        source_pos_next = step_elec(source_pos, cfg.count, cfg.scan_direction);
        sink_pos_next   = step_elec(sink_pos, cfg.count, cfg.scan_direction);
      end
      step_in_frame_next = frame_end ? 4'd0 : step_inc[3:0];
    end

    res.current_mux_byte = {sink_pos_next, source_pos_next};
    res.voltage_mux_byte = {sense_neg_next, sense_pos_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_pos    <= 4'd1;
      sink_pos      <= 4'd0;
      sense_pos     <= 4'd1;
      sense_neg     <= 4'd0;
      step_in_frame <= 4'd0;
    end else if (accept) begin
      source_pos    <= source_pos_next;
      sink_pos      <= sink_pos_next;
      sense_pos     <= sense_pos_next;
      sense_neg     <= sense_neg_next;
      step_in_frame <= step_in_frame_next;
    end
  end

endmodule

// ===== src/ert_electrode_scan_sequencer_core.sv =====
// Electrode scan sequencer top level: handshake and result register.
// A start word (cmd 0) loads the mode's first electrodes; outside standby a
// measure word (cmd 1) returns the offset-corrected voltage tagged with the
// electrodes used plus the mux bytes for the next step. Each input word
// yields exactly one result word, in the cycle after acceptance, from a
// single result register; a new word is accepted whenever that register is
// empty or being read in the same cycle, so throughput is one word per cycle
// under no back-pressure. Configuration writes are registered and must only
// be issued while no result is pending.
module ert_electrode_scan_sequencer_core import ert_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [15:0]        adc_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               sample_valid,
  output logic signed [15:0] voltage,
  output logic [3:0]         sense_pos_used,
  output logic [3:0]         source_used,
  output logic [3:0]         sink_used,
  output logic [7:0]         current_mux_byte,
  output logic [7:0]         voltage_mux_byte,
  output logic               frame_last,
  output logic               mux_disable
);

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  ert_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ert_scan_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .cmd     (cmd),
    .adc_raw (adc_raw),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign sample_valid     = res_q.sample_valid;
  assign voltage          = res_q.voltage;
  assign sense_pos_used   = res_q.sense_pos_used;
  assign source_used      = res_q.source_used;
  assign sink_used        = res_q.sink_used;
  assign current_mux_byte = res_q.current_mux_byte;
  assign voltage_mux_byte = res_q.voltage_mux_byte;
  assign frame_last       = res_q.frame_last;
  assign mux_disable      = res_q.mux_disable;

endmodule

// ===== tb/tb.sv =====
// Testbench for the electrode scan sequencer: directed table, then random scan phases.
`timescale 1ns / 1ps

module tb;
  import ert_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_DRIVE_MODE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_START;
  logic [15:0] adc_raw = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;

  logic               sample_valid;
  logic signed [15:0] voltage;
  logic [3:0]         sense_pos_used;
  logic [3:0]         source_used;
  logic [3:0]         sink_used;
  logic [7:0]         current_mux_byte;
  logic [7:0]         voltage_mux_byte;
  logic               frame_last;
  logic               mux_disable;

  ert_electrode_scan_sequencer_core dut (.*);

  always #6 clk = ~clk;

  // scan predictor: configuration and electrode state as the block holds them
  logic [2:0]  mode_q = RST_DRIVE_MODE;
  logic [1:0]  dir_q  = RST_SCAN_DIRECTION;
  logic [4:0]  cnt_q  = RST_ELECTRODE_COUNT;
  logic [15:0] ofs_q  = RST_GROUND_OFFSET;
  logic [3:0]  src_q  = 4'd1;
  logic [3:0]  snk_q  = 4'd0;
  logic [3:0]  vp_q   = 4'd1;
  logic [3:0]  vn_q   = 4'd0;
  logic [3:0]  step_q = 4'd0;

  res_t scan_results_due[$];
  int   err_count = 0;
  int   nres = 0;
  int   fed = 0;
  int   snd_idle = 26;
  int   rcv_idle = 53;
  int   stall_left = 0;
  bit   held_once = 1'b0;

  function automatic logic [3:0] next_elec(logic [3:0] v, logic [4:0] n);
    case (dir_q)
      DIR_UP:   return ({1'b0, v} + 5'd1 < n) ? v + 4'd1 : 4'd0;
      DIR_DOWN: return (v != 4'd0) ? v - 4'd1 : 4'(n - 5'd1);
      default:  return v;
    endcase
  endfunction

  function automatic res_t next_scan_result(logic c, logic [15:0] raw);
    res_t r;
    logic [4:0] n;
    logic idle;
    r = '0;
    n = (cnt_q < MIN_COUNT) ? MIN_COUNT : (cnt_q > MAX_COUNT) ? MAX_COUNT : cnt_q;
    idle = (mode_q == MODE_STANDBY) || (mode_q > MODE_PP_BOTH);
    if (c == CMD_START) begin
      step_q = '0;
      case (mode_q)
        MODE_CALIBRATE, MODE_ADJACENT: begin
          src_q = 4'd1; snk_q = 4'd0; vp_q = 4'd1; vn_q = 4'd0;
        end
        MODE_PP: begin
          src_q = 4'd0; snk_q = PP_SINK; vp_q = 4'd0; vn_q = PP_SENSE_NEG;
        end
        MODE_PP_BOTH: begin
          src_q = 4'd0; snk_q = PP_SINK; vp_q = 4'd0; vn_q = PP_SINK;
        end
        default: ;
      endcase
    end else if (!idle) begin
      r.sample_valid   = 1'b1;
      r.voltage        = raw - ofs_q;
      r.sense_pos_used = vp_q;
      r.source_used    = src_q;
      r.sink_used      = snk_q;
      vp_q = next_elec(vp_q, n);
      vn_q = next_elec(vn_q, n);
      // a step count left over from a larger electrode count still ends the frame
      if ({1'b0, step_q} + 5'd1 >= n) begin
        r.frame_last = 1'b1;
        step_q = '0;
      end else begin
        step_q = step_q + 4'd1;
      end
      if (mode_q == MODE_CALIBRATE || (mode_q == MODE_ADJACENT && r.frame_last)) begin
        snk_q = next_elec(snk_q, n);
        src_q = next_elec(src_q, n);
      end
    end
    r.current_mux_byte = {snk_q, src_q};
    r.voltage_mux_byte = {vn_q, vp_q};
    r.mux_disable      = idle;
    return r;
  endfunction

  task automatic flag_field(string what, logic [15:0] got, logic [15:0] want);
    $display("tb: mismatch on %s at result %0d: got %0h, want %0h", what, nres, got, want);
    err_count++;
  endtask

  // registers change only with the result register empty
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    in_valid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DRIVE_MODE:      mode_q = data[2:0];
      REG_SCAN_DIRECTION:  dir_q  = data[1:0];
      REG_ELECTRODE_COUNT: cnt_q  = data[4:0];
      REG_GROUND_OFFSET:   ofs_q  = data;
      default: ;
    endcase
  endtask

  task automatic send_item(logic c, logic [15:0] raw, bit known, res_t want);
    res_t pred;
    cfg_valid <= 1'b0;
    in_valid  <= 1'b1;
    cmd       <= c;
    adc_raw   <= raw;
    do @(posedge clk); while (!in_ready);
    pred = next_scan_result(c, raw);
    scan_results_due.push_back(known ? want : pred);
    if (!(c == CMD_MEASURE && pred.mux_disable)) fed++;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // receiver: checks each word against the oldest prediction, stalls at random
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (scan_results_due.size() == 0) begin
        flag_field("result with none pending", 16'd0, 16'd0);
      end else begin
        want = scan_results_due.pop_front();
        if (sample_valid !== want.sample_valid)
          flag_field("sample_valid", 16'(sample_valid), 16'(want.sample_valid));
        if (voltage !== want.voltage)
          flag_field("voltage", voltage, want.voltage);
        if (sense_pos_used !== want.sense_pos_used)
          flag_field("sense_pos_used", 16'(sense_pos_used), 16'(want.sense_pos_used));
        if (source_used !== want.source_used)
          flag_field("source_used", 16'(source_used), 16'(want.source_used));
        if (sink_used !== want.sink_used)
          flag_field("sink_used", 16'(sink_used), 16'(want.sink_used));
        if (current_mux_byte !== want.current_mux_byte)
          flag_field("current_mux_byte", 16'(current_mux_byte),
                     16'(want.current_mux_byte));
        if (voltage_mux_byte !== want.voltage_mux_byte)
          flag_field("voltage_mux_byte", 16'(voltage_mux_byte),
                     16'(want.voltage_mux_byte));
        if (frame_last !== want.frame_last)
          flag_field("frame_last", 16'(frame_last), 16'(want.frame_last));
        if (mux_disable !== want.mux_disable)
          flag_field("mux_disable", 16'(mux_disable), 16'(want.mux_disable));
      end
      nres++;
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!held_once && nres >= 150 && in_valid) begin
      // long hold-off while words keep coming, so the input backs up
      out_ready  <= 1'b0;
      stall_left <= 60;
      held_once  <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  typedef struct {
    bit          is_reg;
    logic [1:0]  idx;
    logic [15:0] data;
    logic        c;
    logic [15:0] raw;
    bit          known;
    res_t        want;
  } row_t;

  function automatic row_t reg_row(logic [1:0] idx, logic [15:0] data);
    return '{1'b1, idx, data, CMD_START, 16'd0, 1'b0, res_t'('0)};
  endfunction

  function automatic row_t item_row(logic c, logic [15:0] raw);
    return '{1'b0, REG_DRIVE_MODE, 16'd0, c, raw, 1'b0, res_t'('0)};
  endfunction

  function automatic row_t known_row(logic c, logic [15:0] raw, res_t want);
    return '{1'b0, REG_DRIVE_MODE, 16'd0, c, raw, 1'b1, want};
  endfunction

  initial begin
    row_t        plan[$];
    int          len;
    int          pick;
    logic [15:0] word;
    logic        c;
    logic [15:0] raw;

    // reset config: adjacent, upward, 16 electrodes, offset 31360
    plan.push_back(known_row(CMD_START, 16'd0,
                   res_t'{1'b0, 16'sd0, 4'd0, 4'd0, 4'd0, 8'h01, 8'h01, 1'b0, 1'b0}));
    plan.push_back(known_row(CMD_MEASURE, 16'd31360,
                   res_t'{1'b1, 16'sd0, 4'd1, 4'd1, 4'd0, 8'h01, 8'h12, 1'b0, 1'b0}));
    plan.push_back(known_row(CMD_MEASURE, 16'h0000,
                   res_t'{1'b1, 16'sh8580, 4'd2, 4'd1, 4'd0, 8'h01, 8'h23, 1'b0, 1'b0}));
    plan.push_back(item_row(CMD_MEASURE, 16'hFFFF));
    plan.push_back(item_row(CMD_MEASURE, 16'h7FFF));
    plan.push_back(item_row(CMD_MEASURE, 16'h8000));
    plan.push_back(item_row(CMD_MEASURE, 16'h8001));
    plan.push_back(item_row(CMD_MEASURE, 16'h5A5A));
    plan.push_back(item_row(CMD_MEASURE, 16'hA5A5));
    // count below range saturates to 8; step count 8 is now stale
    plan.push_back(reg_row(REG_ELECTRODE_COUNT, 16'hFFE7));
    plan.push_back(item_row(CMD_MEASURE, 16'h0001));
    // calibrate, downward, count above range, top offset
    plan.push_back(reg_row(REG_DRIVE_MODE, 16'hFFF9));
    plan.push_back(reg_row(REG_SCAN_DIRECTION, 16'h0000));
    plan.push_back(reg_row(REG_ELECTRODE_COUNT, 16'h001F));
    plan.push_back(reg_row(REG_GROUND_OFFSET, 16'hFFFF));
    plan.push_back(item_row(CMD_START, 16'hFFFF));
    plan.push_back(item_row(CMD_MEASURE, 16'h0000));
    plan.push_back(item_row(CMD_MEASURE, 16'hFFFF));
    plan.push_back(item_row(CMD_MEASURE, 16'h0001));
    // pseudo polar with the unused direction code (holds)
    plan.push_back(reg_row(REG_DRIVE_MODE, {13'h0000, MODE_PP}));
    plan.push_back(reg_row(REG_SCAN_DIRECTION, 16'h0003));
    plan.push_back(item_row(CMD_START, 16'h0000));
    plan.push_back(item_row(CMD_MEASURE, 16'h8000));
    plan.push_back(reg_row(REG_DRIVE_MODE, {13'h0000, MODE_PP_BOTH}));
    plan.push_back(reg_row(REG_SCAN_DIRECTION, {14'h0000, DIR_UP}));
    plan.push_back(item_row(CMD_START, 16'h0000));
    plan.push_back(item_row(CMD_MEASURE, 16'hFFFE));
    // standby and an unused mode code
    plan.push_back(reg_row(REG_DRIVE_MODE, {13'h1FFF, MODE_STANDBY}));
    plan.push_back(item_row(CMD_MEASURE, 16'h1111));
    plan.push_back(item_row(CMD_START, 16'h0000));
    plan.push_back(reg_row(REG_DRIVE_MODE, 16'h0007));
    plan.push_back(item_row(CMD_MEASURE, 16'h2222));
    plan.push_back(item_row(CMD_START, 16'h0000));
    plan.push_back(reg_row(REG_DRIVE_MODE, {13'h0000, MODE_ADJACENT}));
    plan.push_back(reg_row(REG_GROUND_OFFSET, 16'h0000));
    plan.push_back(reg_row(REG_ELECTRODE_COUNT, 16'h0008));
    plan.push_back(item_row(CMD_START, 16'h0000));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].idx, plan[i].data);
      else send_item(plan[i].c, plan[i].raw, plan[i].known, plan[i].want);
    end

    fed = 0;
    while (fed < 500) begin
      pick = $urandom_range(19);
      word = 16'($urandom);
      word[2:0] = (pick == 0) ? MODE_STANDBY :
                  (pick == 1) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(1, 4));
      write_reg(REG_DRIVE_MODE, word);
      word = 16'($urandom);
      write_reg(REG_SCAN_DIRECTION, word);
      pick = $urandom_range(9);
      word = 16'($urandom);
      word[4:0] = (pick == 0) ? 5'($urandom_range(0, 7)) :
                  (pick == 1) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(8, 16));
      write_reg(REG_ELECTRODE_COUNT, word);
      pick = $urandom_range(9);
      word = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      write_reg(REG_GROUND_OFFSET, word);

      len = $urandom_range(8, 40);
      for (int k = 0; k < len; k++) begin
        if (fed < 167) begin
          snd_idle = 26; rcv_idle = 53;
        end else if (fed < 334) begin
          snd_idle = 53; rcv_idle = 26;
        end else begin
          snd_idle = 0; rcv_idle = 0;
        end
        if ((k == 0 && $urandom_range(9) != 0) || $urandom_range(19) == 0)
          c = CMD_START;
        else
          c = CMD_MEASURE;
        pick = $urandom_range(9);
        raw = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
              (pick == 2) ? ofs_q : (pick == 3) ? (ofs_q ^ 16'h8000) : 16'($urandom);
        send_item(c, raw, 1'b0, res_t'('0));
      end
    end

    in_valid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ert_pkg.sv
src/ert_cfg_regs.sv
src/ert_scan_core.sv
src/ert_electrode_scan_sequencer_core.sv
tb/tb.sv
